// File: hdl/assert_macros.svh
// assertion macros shared by the date adder modules
// each module that includes this file must have clock and reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define CHECK_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CHECK_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/gdadd_pkg.sv
// shared types, constants and calendar tables for the date adder
// no dependencies
package gdadd_pkg;

   localparam int DAY_COUNT_BITS = 16;
   localparam int TOT_W          = DAY_COUNT_BITS + 2;
   localparam int YEAR_W         = 15;
   localparam int PROD_W         = 28;
   localparam int Q_W            = 8;
   localparam int R_W            = 7;

   localparam logic [YEAR_W-1:0] YEAR_TOP      = YEAR_W'(9999);
   localparam logic [13:0]       YEAR_TOP_OUT  = 14'd9999;
   localparam logic [3:0]        MONTH_DEC     = 4'd12;
   localparam logic [4:0]        DAY_DEC_END   = 5'd31;
   localparam logic [3:0]        LAST_MONTH_IX = 4'd11;
   localparam logic [3:0]        FEB_IX        = 4'd1;
   // reciprocal of 100 scaled by 2^19, exact for years below 2^14
   localparam logic [12:0]       RECIP_100     = 13'd5243;
   localparam int                RECIP_SHIFT   = 19;
   localparam logic [R_W-1:0]    CENTURY_LAST  = R_W'(99);
   localparam logic [8:0]        DAYS_LEAP     = 9'd366;
   localparam logic [8:0]        DAYS_COMMON   = 9'd365;
   localparam logic [4:0]        FEB_LEAP_LEN  = 5'd29;

   typedef struct packed {
      logic [13:0] start_year;
      logic [3:0]  start_month;
      logic [4:0]  start_day;
      logic [15:0] days_to_add;
   } req_type;

   typedef struct packed {
      logic [13:0] result_year;
      logic [3:0]  result_month;
      logic [4:0]  result_day;
      logic        year_overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_SPLIT,
      ST_DOY,
      ST_YEAR,
      ST_MONTH,
      ST_PUT
   } state_type;

   typedef struct packed {
      logic load;
      logic mult;
      logic split;
      logic doy;
      logic year_step;
      logic month_step;
      logic put;
   } cmd_type;

   typedef struct packed {
      logic year_more;
      logic over_top;
      logic month_more;
      logic out_free;
   } status_type;

   // common-year month length, month index from 0
   function automatic logic [4:0] month_len(input logic [3:0] m0);
      logic [4:0] len;
      case (m0)
         4'd1:    len = 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [4:0] mlen(input logic leap, input logic [3:0] m0);
      logic [4:0] len;
      if (leap && m0 == FEB_IX) len = FEB_LEAP_LEN;
      else                      len = month_len(m0);
      return len;
   endfunction

   // days before the month in a common year, month index from 0
   function automatic logic [8:0] days_before(input logic [3:0] m0);
      logic [8:0] sum;
      case (m0)
         4'd0:    sum = 9'd0;
         4'd1:    sum = 9'd31;
         4'd2:    sum = 9'd59;
         4'd3:    sum = 9'd90;
         4'd4:    sum = 9'd120;
         4'd5:    sum = 9'd151;
         4'd6:    sum = 9'd181;
         4'd7:    sum = 9'd212;
         4'd8:    sum = 9'd243;
         4'd9:    sum = 9'd273;
         4'd10:   sum = 9'd304;
         default: sum = 9'd334;
      endcase
      return sum;
   endfunction

endpackage

// File: hdl/gdadd_ctrl.sv
// sequencer for the date adder: issues datapath commands per step
// depends on gdadd_pkg and assert_macros.svh
`include "assert_macros.svh"

module gdadd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  gdadd_pkg::status_type   status,
   output gdadd_pkg::cmd_type      cmd
);
   import gdadd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = ST_DOY;
         end
         ST_DOY: begin
            cmd.doy  = 1'b1;
            state_in = ST_YEAR;
         end
         ST_YEAR: begin
            if (status.over_top)       state_in = ST_PUT;
            else if (status.year_more) cmd.year_step = 1'b1;
            else                       state_in = ST_MONTH;
         end
         ST_MONTH: begin
            if (status.month_more) cmd.month_step = 1'b1;
            else                   state_in = ST_PUT;
         end
         ST_PUT: begin
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `CHECK_NEXT(a_accept_to_mult, req_valid && !req_stall, state_ff == ST_MULT, "no start")
   `CHECK_SAME(a_put_free, cmd.put, status.out_free, "result written over waiting result")
   `CHECK_SAME(a_one_step, cmd.year_step, !cmd.month_step && !cmd.put, "overlapping commands")

endmodule

// File: hdl/gdadd_dp.sv
// datapath for the date adder: year, century split, running day count, result register
// depends on gdadd_pkg and assert_macros.svh
`include "assert_macros.svh"

module gdadd_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  gdadd_pkg::req_type      req_data,
   output gdadd_pkg::rsp_type      rsp_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  gdadd_pkg::cmd_type      cmd,
   output gdadd_pkg::status_type   status
);
   import gdadd_pkg::*;

   logic [YEAR_W-1:0]         y_ff, y_in;
   logic [3:0]                m_ff, m_in;
   logic [4:0]                d_ff, d_in;
   logic [DAY_COUNT_BITS-1:0] add_ff, add_in;
   logic [PROD_W-1:0]         p_ff, p_in;
   logic [Q_W-1:0]            q_ff, q_in;
   logic [R_W-1:0]            r_ff, r_in;
   logic [TOT_W-1:0]          tot_ff, tot_in;
   logic [3:0]                m0_ff, m0_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic              leap;
   logic [8:0]        ylen;
   logic [4:0]        cur_mlen;
   logic [4:0]        start_mlen;
   logic [4:0]        d_clamped;
   logic [Q_W-1:0]    q_split;
   logic [YEAR_W-1:0] q_times_100;
   logic [3:0]        start_m0;
   logic              month_ok;
   logic              sat_ok;

   // century test uses the split year: quotient and remainder by 100
   assign leap       = (r_ff == '0) ? (q_ff[1:0] == 2'b00) : (y_ff[1:0] == 2'b00);
   assign ylen       = leap ? DAYS_LEAP : DAYS_COMMON;
   assign cur_mlen   = mlen(leap, m0_ff);
   assign start_m0   = m_ff - 4'd1;
   assign start_mlen = mlen(leap, start_m0);
   assign d_clamped  = (d_ff > start_mlen) ? start_mlen : d_ff;
   assign q_split    = p_ff[RECIP_SHIFT +: Q_W];
   assign q_times_100 = YEAR_W'(q_split) * YEAR_W'(100);

   assign status.year_more  = tot_ff > TOT_W'(ylen);
   assign status.over_top   = y_ff > YEAR_TOP;
   assign status.month_more = (m0_ff < LAST_MONTH_IX) && (tot_ff > TOT_W'(cur_mlen));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      y_in         = y_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      add_in       = add_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      tot_in       = tot_ff;
      m0_in        = m0_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         y_in   = (req_data.start_year == '0) ? YEAR_W'(1) : YEAR_W'(req_data.start_year);
         if (req_data.start_month == '0)           m_in = 4'd1;
         else if (req_data.start_month > MONTH_DEC) m_in = MONTH_DEC;
         else                                       m_in = req_data.start_month;
         d_in   = (req_data.start_day == '0) ? 5'd1 : req_data.start_day;
         add_in = req_data.days_to_add[DAY_COUNT_BITS-1:0];
         m0_in  = '0;
      end
      if (cmd.mult) begin
         p_in = PROD_W'(y_ff) * PROD_W'(RECIP_100);
      end
      if (cmd.split) begin
         q_in = q_split;
         r_in = R_W'(y_ff - q_times_100);
      end
      if (cmd.doy) begin
         tot_in = TOT_W'(days_before(start_m0))
                + TOT_W'(leap && (m_ff > 4'd2))
                + TOT_W'(d_clamped)
                + TOT_W'(add_ff);
      end
      if (cmd.year_step) begin
         tot_in = tot_ff - TOT_W'(ylen);
         y_in   = y_ff + YEAR_W'(1);
         if (r_ff == CENTURY_LAST) begin
            r_in = '0;
            q_in = q_ff + Q_W'(1);
         end else begin
            r_in = r_ff + R_W'(1);
         end
      end
      if (cmd.month_step) begin
         tot_in = tot_ff - TOT_W'(cur_mlen);
         m0_in  = m0_ff + 4'd1;
      end
      if (cmd.put) begin
         rsp_valid_in = 1'b1;
         if (status.over_top) begin
            rsp_in.result_year   = YEAR_TOP_OUT;
            rsp_in.result_month  = MONTH_DEC;
            rsp_in.result_day    = DAY_DEC_END;
            rsp_in.year_overflow = 1'b1;
         end else begin
            rsp_in.result_year   = y_ff[13:0];
            rsp_in.result_month  = m0_ff + 4'd1;
            rsp_in.result_day    = tot_ff[4:0];
            rsp_in.year_overflow = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      y_ff   <= y_in;
      m_ff   <= m_in;
      d_ff   <= d_in;
      add_ff <= add_in;
      p_ff   <= p_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      tot_ff <= tot_in;
      m0_ff  <= m0_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // terms for the result checks
   assign month_ok = (rsp_ff.result_month >= 4'd1) && (rsp_ff.result_month <= MONTH_DEC);
   assign sat_ok   = rsp_ff.result_year == YEAR_TOP_OUT;

   `CHECK_SAME(a_rem_range, cmd.year_step, r_ff <= CENTURY_LAST, "year remainder out of range")
   `CHECK_SAME(a_month_range, rsp_valid_ff, month_ok, "bad month")
   `CHECK_SAME(a_over_sat, rsp_valid_ff && rsp_ff.year_overflow, sat_ok, "overflow not saturated")

endmodule

// File: hdl/gregorian_date_add_days_core.sv
// Gregorian date adder: takes a start date and a day count, returns the later date.
// One request is handled at a time. After acceptance the block runs four set-up
// steps (load, reciprocal multiply for the century split, split, day of year), then
// steps one whole year per cycle off the running day count (up to about 180 years
// for the largest count), then, unless the year passed 9999, walks one month per cycle
// in the final year (at most eleven), then writes the result register. The result
// register lets a new request be accepted while the previous result is still stalled.
// Years past 9999 are flagged on year_overflow and saturated to 9999-12-31. Out of
// range inputs are clamped: year 0 and month 0 and day 0 read as 1, month above 12
// as 12, and a day past the month end as the last day of that month.
// Depends on gdadd_pkg, gdadd_ctrl and gdadd_dp.

module gregorian_date_add_days_core (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gdadd_pkg::req_type   req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gdadd_pkg::rsp_type   rsp_data
);
   import gdadd_pkg::*;

   // command bundle from the sequencer and status flags back from the datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: one state per set-up step after the load, then the year and month walks
   gdadd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: year with its century split, running day count, result register
   gdadd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: verif/tb_gregorian_date_add_days_core.sv
`timescale 1ns / 1ps
// testbench for gregorian_date_add_days_core: directed and random date requests,
// each result checked field by field against a date predictor held here
// depends on gdadd_pkg and the gregorian_date_add_days_core rtl

module tb_gregorian_date_add_days_core;

   import gdadd_pkg::req_type;
   import gdadd_pkg::rsp_type;

   localparam int YEAR_MAX       = 9999;
   localparam int LAST_MONTH     = 12;
   localparam int LAST_MONTH_IX  = 11;
   localparam int LAST_DAY       = 31;
   localparam int HOLD_OFF_LEN   = 600;   // long receiver hold-off, in cycles
   localparam int SETTLE_CYCLES  = 250;   // a little over the worst request latency
   localparam int QUIET_LIMIT    = 4000;  // cycles with no handshake before giving up
   localparam int PRINT_CAP      = 40;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_dates [$];   // requests waiting to be offered
   rsp_type expected_dates [$];  // predicted dates, oldest first

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_off_asks = 0;        // bumped by the stimulus to ask for a long hold-off
   int hold_off_seen = 0;
   int hold_left     = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;

   gregorian_date_add_days_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- calendar

   // divisible by 4, but centuries only when divisible by 400
   function automatic bit is_leap_year(input int y);
      if (y % 100 == 0) return (y % 400) == 0;
      return (y % 4) == 0;
   endfunction

   function automatic int year_days(input int y);
      return is_leap_year(y) ? 366 : 365;
   endfunction

   // month index counts from 0 for january
   function automatic int month_days(input int y, input int m0);
      int len;
      case (m0)
         1:       len = is_leap_year(y) ? 29 : 28;
         3, 5, 8, 10: len = 30;
         default: len = 31;
      endcase
      return len;
   endfunction

   // date that lies days_to_add days after the (clamped) start date
   function automatic rsp_type advance_date(input req_type rq);
      int      y, m, d, total, m0;
      rsp_type r;
      y = rq.start_year;
      m = rq.start_month;
      d = rq.start_day;
      // out of range fields are pulled back into the calendar first
      if (y == 0) y = 1;
      if (m == 0) m = 1;
      if (m > LAST_MONTH) m = LAST_MONTH;
      if (d == 0) d = 1;
      if (d > month_days(y, m - 1)) d = month_days(y, m - 1);
      // day of year from 1, plus the count
      total = d;
      for (m0 = 0; m0 < m - 1; m0++) total += month_days(y, m0);
      total += rq.days_to_add;
      // step off whole years
      while (total > year_days(y)) begin
         total -= year_days(y);
         y++;
      end
      if (y > YEAR_MAX) begin
         // past the top of the range: flag and saturate to the last day
         r.result_year   = 14'(YEAR_MAX);
         r.result_month  = 4'(LAST_MONTH);
         r.result_day    = 5'(LAST_DAY);
         r.year_overflow = 1'b1;
      end else begin
         m0 = 0;
         while (m0 < LAST_MONTH_IX && total > month_days(y, m0)) begin
            total -= month_days(y, m0);
            m0++;
         end
         r.result_year   = 14'(y);
         r.result_month  = 4'(m0 + 1);
         r.result_day    = 5'(total);
         r.year_overflow = 1'b0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP) $display("%0t ns: mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_dates.size() == 0) begin
         report_mismatch($sformatf("result %0d-%0d-%0d with no request outstanding",
                                   got.result_year, got.result_month, got.result_day));
      end else begin
         want = expected_dates.pop_front();
         if (got.result_year !== want.result_year)
            report_mismatch($sformatf("year %0d, expected %0d",
                                      got.result_year, want.result_year));
         if (got.result_month !== want.result_month)
            report_mismatch($sformatf("month %0d, expected %0d",
                                      got.result_month, want.result_month));
         if (got.result_day !== want.result_day)
            report_mismatch($sformatf("day %0d, expected %0d",
                                      got.result_day, want.result_day));
         if (got.year_overflow !== want.year_overflow)
            report_mismatch($sformatf("overflow %b, expected %b",
                                      got.year_overflow, want.year_overflow));
      end
   endtask

   // ---------------------------------------------------------------- driver

   // a request is predicted on the edge at which it is accepted; a new one is
   // only put up once the previous one has gone, so a stalled payload holds
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_dates.push_back(advance_date(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_dates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_dates.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // also owns the receiver stall, including the long hold-off countdown
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (hold_off_asks != hold_off_seen) begin
            hold_off_seen = hold_off_asks;
            hold_left     = HOLD_OFF_LEN;
            rsp_stall    <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_gregorian_date_add_days_core: done, errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_date(input int y, input int m, input int d, input int n);
      req_type rq;
      rq.start_year  = 14'(y);
      rq.start_month = 4'(m);
      rq.start_day   = 5'(d);
      rq.days_to_add = 16'(n);
      pending_dates.push_back(rq);
   endtask

   // mostly valid dates, some close to the top year, some raw noise; most
   // counts small because the block needs a cycle per year stepped
   task automatic add_random_dates(input int count);
      req_type rq;
      int      pick, span, y, m;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            rq.start_year  = 14'($urandom);
            rq.start_month = 4'($urandom);
            rq.start_day   = 5'($urandom);
         end else begin
            y = (pick < 30) ? $urandom_range(YEAR_MAX, 9700) : $urandom_range(YEAR_MAX, 1);
            m = $urandom_range(LAST_MONTH, 1);
            rq.start_year  = 14'(y);
            rq.start_month = 4'(m);
            rq.start_day   = 5'($urandom_range(month_days(y, m - 1), 1));
         end
         span = $urandom_range(99);
         if (span < 60)      rq.days_to_add = 16'($urandom_range(400, 0));
         else if (span < 85) rq.days_to_add = 16'($urandom_range(5000, 0));
         else                rq.days_to_add = 16'($urandom);
         pending_dates.push_back(rq);
      end
   endtask

   // waits until every queued request has been sent and every predicted date has come back
   task automatic wait_drained;
      while (pending_dates.size() != 0 || req_valid || expected_dates.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_in, input int count);
      @(negedge clock);
      send_idle_pct = idle_pct;
      stall_pct     = stall_in;
      add_random_dates(count);
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed requests, no idling
      add_date(2000, 2, 28, 1);          // leap century
      add_date(1900, 2, 28, 1);          // century that is not leap
      add_date(2024, 12, 31, 1);         // year carry
      add_date(2023, 1, 31, 28);         // month carry into a common february
      add_date(2024, 1, 31, 29);
      add_date(1, 1, 1, 0);              // lowest date, nothing added
      add_date(1, 1, 1, 65535);          // largest count
      add_date(9999, 12, 31, 0);         // top date, still in range
      add_date(9999, 12, 31, 1);         // just past the top
      add_date(9800, 1, 1, 65535);       // largest count from a high year, still in range
      add_date(0, 0, 0, 5);              // zero year, month and day
      add_date(2023, 15, 31, 0);         // month above december
      add_date(2023, 2, 31, 0);          // day past month end
      add_date(2024, 2, 31, 0);
      add_date(2024, 4, 31, 1);
      add_date(10000, 1, 1, 0);          // start year above the range
      add_date(16383, 15, 31, 65535);    // every field at its top value
      add_date(2024, 2, 29, 365);
      add_date(2100, 3, 1, 36524);
      add_date(2000, 12, 31, 366);
      wait_drained();

      // block fills up behind a long hold-off while requests keep coming
      @(negedge clock);
      add_random_dates(150);
      hold_off_asks++;
      wait_drained();

      run_phase(0, 0, 200);
      run_phase(66, 0, 300);
      run_phase(0, 66, 300);
      run_phase(23, 23, 300);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_dates.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_dates.size()));
      if (error_count == 0) begin
         $display("tb_gregorian_date_add_days_core: done, clean");
      end else begin
         $display("tb_gregorian_date_add_days_core: done, errors");
      end
      $finish;
   end

endmodule
